>>> hw/rtl/coalescing_range_table_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the coalescing range table
// Shorthand for clocked implication checks, reset-qualified on arst_n.
// -----------------------------------------------------------------------------
`ifndef COALESCING_RANGE_TABLE_ASSERT_SVH
`define COALESCING_RANGE_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/crt_pkg.sv
// -----------------------------------------------------------------------------
// crt_pkg
// Request and status codes, table entry and result record types.
// -----------------------------------------------------------------------------
package crt_pkg;

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_REMOVE  = 3'd1;
	localparam logic [2:0] REQ_FIND    = 3'd2;
	localparam logic [2:0] REQ_NEAREST = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic [31:0] value;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] start;
		logic [31:0] length;
		logic [31:0] value;
		logic [31:0] m1;
		logic [31:0] m2;
		logic [1:0]  mcount;
		logic [5:0]  rcount;
		logic        last;
	} result_t;

endpackage

>>> hw/rtl/coalescing_range_table.sv
// -----------------------------------------------------------------------------
// coalescing_range_table
// Sorted table of non-overlapping intervals with coalescing insert, cutting
// remove, containing and nearest lookup, and clear.
// -----------------------------------------------------------------------------
// The table lives in a single-port-write, single-port-read memory walked one
// entry at a time by a small sequencer; the block takes one request and holds
// in_stall high until its last result beat has been handed to the output
// register. Each table access is a read step followed by an evaluate or write
// step. A find scans the stored entries; a clear, an unknown request or a bad
// range skips the table; an insert or a remove scans up to the insertion
// point, then shifts or compacts the rest of the table. Stalls on the output
// side also hold in_stall high. A remove emits one beat per wholly deleted
// interval, in ascending order, followed by a final beat with the deleted
// count and last set.
// Entries are never cleared: reads only ever touch indices below the entry
// count.
// -----------------------------------------------------------------------------
`include "coalescing_range_table_assert.svh"

module coalescing_range_table #(
	parameter int DEPTH      = 32,
	parameter int ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] req_start,
	input  logic [31:0] req_length,
	input  logic [31:0] new_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] range_start,
	output logic [31:0] range_length,
	output logic [31:0] entry_value,
	output logic [31:0] merged_value,
	output logic [31:0] merged_value_two,
	output logic [1:0]  merged_count,
	output logic [5:0]  deleted_count,
	output logic        last
);
	import crt_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [32:0] ADDR_LIMIT = (ADDR_WIDTH >= 32) ? 33'h0_FFFF_FFFF :
		33'((64'd1 << ADDR_WIDTH) - 64'd1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_SCAN_RD = 13'b0000000000010,
		S_SCAN_EV = 13'b0000000000100,
		S_DECIDE  = 13'b0000000001000,
		S_SHUP_RD = 13'b0000000010000,
		S_SHUP_WR = 13'b0000000100000,
		S_SHDN_RD = 13'b0000001000000,
		S_SHDN_WR = 13'b0000010000000,
		S_WR_A    = 13'b0000100000000,
		S_WR_B    = 13'b0001000000000,
		S_RM_RD   = 13'b0010000000000,
		S_RM_EV   = 13'b0100000000000,
		S_EMIT    = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [2:0]      op_q;
	logic [31:0]     s_q, len_q, val_q;
	logic [32:0]     e_q;
	logic            rng_ok_q;
	logic [CW-1:0]   n_q, nn_q, i_q, m_q, k_q, lo_q;
	logic            found_q, two_q;
	entry_t          cur_q, p1_q, p2_q;
	logic [IW-1:0]   wa_addr_q, wb_addr_q;
	entry_t          wa_data_q, wb_data_q;
	result_t         res_q, out_q;
	logic            out_valid_q;

	// table memory
	entry_t          mem_q [DEPTH];
	entry_t          rd_q;
	logic            re, we;
	logic [IW-1:0]   ra, wa;
	entry_t          wd;

	logic [CW-1:0]   i_dec, i_inc;
	logic [CW:0]     i_inc2, n_ext;
	logic [32:0]     x_end, cur_end, p1_end, p2_end, e_in;
	logic            out_free, ld;
	result_t         ld_res;

	// remove classification of the entry just read
	logic            rm_keep, rm_del;
	// nearest selection
	entry_t          cand, prv;
	logic            have_prv;
	logic [32:0]     cand_end, prv_end, dc, dp;

	// decision taken once the scan has stopped
	result_t         d_res;
	state_t          d_state;
	logic [CW-1:0]   d_nn, d_n, d_lo, d_i, d_m;
	logic            d_two;
	logic [IW-1:0]   d_wa_addr, d_wb_addr;
	entry_t          d_wa_data, d_wb_data;

	assign i_dec  = i_q - CW'(1);
	assign i_inc  = i_q + CW'(1);
	assign i_inc2 = {1'b0, i_q} + (CW + 1)'(2);
	assign n_ext  = {1'b0, n_q};
	assign x_end   = {1'b0, rd_q.start} + {1'b0, rd_q.length};
	assign cur_end = {1'b0, cur_q.start} + {1'b0, cur_q.length};
	assign p1_end  = {1'b0, p1_q.start} + {1'b0, p1_q.length};
	assign p2_end  = {1'b0, p2_q.start} + {1'b0, p2_q.length};
	assign e_in    = {1'b0, req_start} + {1'b0, req_length};

	assign rm_keep = (x_end <= {1'b0, s_q}) || ({1'b0, rd_q.start} >= e_q);
	assign rm_del  = !rm_keep && (rd_q.start >= s_q) && (x_end <= e_q);

	assign cand     = found_q ? cur_q : p1_q;
	assign prv      = found_q ? p1_q : p2_q;
	assign have_prv = found_q ? (i_q != '0) : (n_q > CW'(1));
	assign cand_end = {1'b0, cand.start} + {1'b0, cand.length};
	assign prv_end  = found_q ? p1_end : p2_end;
	assign dc = (cand.start > s_q) ? ({1'b0, cand.start} - {1'b0, s_q})
		: ({1'b0, s_q} - cand_end + 33'd1);
	assign dp = {1'b0, s_q} - prv_end + 33'd1;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// memory port control
	always_comb begin
		re = 1'b0;
		we = 1'b0;
		ra = i_q[IW-1:0];
		wa = i_q[IW-1:0];
		wd = rd_q;
		unique case (state_q) inside
			S_SCAN_RD, S_RM_RD: begin
				re = (i_q != n_q);
			end
			S_SHUP_RD: begin
				re = 1'b1;
				ra = i_dec[IW-1:0];
			end
			S_SHDN_RD: begin
				re = 1'b1;
				ra = i_inc[IW-1:0];
			end
			S_SHUP_WR, S_SHDN_WR: begin
				we = 1'b1;
			end
			S_WR_A: begin
				we = 1'b1;
				wa = wa_addr_q;
				wd = wa_data_q;
			end
			S_WR_B: begin
				we = 1'b1;
				wa = wb_addr_q;
				wd = wb_data_q;
			end
			S_RM_EV: begin
				we = !rm_del;
				wa = m_q[IW-1:0];
				if (rm_keep) begin
					wd = rd_q;
				end else if (rd_q.start < s_q) begin
					wd = '{start: rd_q.start, length: s_q - rd_q.start, value: rd_q.value};
				end else begin
					wd = '{start: e_q[31:0], length: 32'(x_end - e_q), value: rd_q.value};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem_q[ra];
		end
	end

	// output beat load
	always_comb begin
		ld     = 1'b0;
		ld_res = res_q;
		if (state_q == S_EMIT) begin
			ld = out_free;
		end else if (state_q == S_RM_EV && rm_del) begin
			ld = out_free;
			ld_res = '{status: ST_OK, start: rd_q.start, length: rd_q.length,
				value: rd_q.value, m1: '0, m2: '0, mcount: '0, rcount: '0, last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
				out_q       <= ld_res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// decide what the request does once the scan has found its place
	always_comb begin
		d_res     = '{status: ST_OK, start: '0, length: '0, value: '0, m1: '0,
			m2: '0, mcount: '0, rcount: '0, last: 1'b1};
		d_nn      = n_q;
		d_n       = n_q;
		d_two     = 1'b0;
		d_state   = S_EMIT;
		d_wa_addr = wa_addr_q;
		d_wa_data = wa_data_q;
		d_wb_addr = wb_addr_q;
		d_wb_data = wb_data_q;
		d_lo      = lo_q;
		d_i       = i_q;
		d_m       = m_q;
		unique case (op_q) inside
			REQ_CLEAR: begin
				d_n = '0;
			end
			REQ_INSERT: begin
				if (!rng_ok_q ||
					((i_q != '0) && (p1_end > {1'b0, s_q})) ||
					(found_q && (e_q > {1'b0, cur_q.start}))) begin
					d_res.status = ST_INVALID;
				end else if ((i_q != '0) && (p1_end == {1'b0, s_q}) &&
					found_q && (e_q == {1'b0, cur_q.start})) begin
					// three-way merge: keep left, drop right, close the gap
					d_wa_addr = i_dec[IW-1:0];
					d_wa_data = '{start: p1_q.start,
						length: p1_q.length + len_q + cur_q.length, value: p1_q.value};
					d_res = '{status: ST_OK, start: p1_q.start,
						length: p1_q.length + len_q + cur_q.length, value: p1_q.value,
						m1: val_q, m2: cur_q.value, mcount: 2'd2, rcount: '0,
						last: 1'b1};
					d_nn    = n_q - CW'(1);
					d_state = (i_inc2 <= n_ext) ? S_SHDN_RD : S_WR_A;
				end else if ((i_q != '0) && (p1_end == {1'b0, s_q})) begin
					d_wa_addr = i_dec[IW-1:0];
					d_wa_data = '{start: p1_q.start, length: p1_q.length + len_q,
						value: p1_q.value};
					d_res = '{status: ST_OK, start: p1_q.start,
						length: p1_q.length + len_q, value: p1_q.value, m1: val_q,
						m2: '0, mcount: 2'd1, rcount: '0, last: 1'b1};
					d_state = S_WR_A;
				end else if (found_q && (e_q == {1'b0, cur_q.start})) begin
					d_wa_addr = i_q[IW-1:0];
					d_wa_data = '{start: s_q, length: cur_q.length + len_q,
						value: val_q};
					d_res = '{status: ST_OK, start: s_q,
						length: cur_q.length + len_q, value: val_q, m1: cur_q.value,
						m2: '0, mcount: 2'd1, rcount: '0, last: 1'b1};
					d_state = S_WR_A;
				end else if (n_q >= DEPTH_C) begin
					d_res.status = ST_FULL;
				end else begin
					d_wa_addr = i_q[IW-1:0];
					d_wa_data = '{start: s_q, length: len_q, value: val_q};
					d_res = '{status: ST_OK, start: s_q, length: len_q,
						value: val_q, m1: '0, m2: '0, mcount: '0, rcount: '0,
						last: 1'b1};
					d_nn    = n_q + CW'(1);
					d_lo    = i_q;
					d_i     = n_q;
					d_state = (n_q > i_q) ? S_SHUP_RD : S_WR_A;
				end
			end
			REQ_REMOVE: begin
				if (!rng_ok_q) begin
					d_res.status = ST_INVALID;
				end else if (found_q && (cur_q.start < s_q) && (cur_end > e_q)) begin
					// request lies strictly inside one entry: split it
					if (n_q >= DEPTH_C) begin
						d_res.status = ST_FULL;
					end else begin
						d_wa_addr = i_inc[IW-1:0];
						d_wa_data = '{start: e_q[31:0], length: 32'(cur_end - e_q),
							value: cur_q.value};
						d_wb_addr = i_q[IW-1:0];
						d_wb_data = '{start: cur_q.start,
							length: s_q - cur_q.start, value: cur_q.value};
						d_two   = 1'b1;
						d_nn    = n_q + CW'(1);
						d_lo    = i_inc;
						d_i     = n_q;
						d_state = (n_q > i_inc) ? S_SHUP_RD : S_WR_A;
					end
				end else begin
					d_m     = i_q;
					d_state = S_RM_RD;
				end
			end
			REQ_FIND, REQ_NEAREST: begin
				if ((i_q != '0) && (p1_end > {1'b0, s_q})) begin
					d_res.start  = p1_q.start;
					d_res.length = p1_q.length;
					d_res.value  = p1_q.value;
				end else if (op_q == REQ_FIND || n_q == '0) begin
					d_res.status = ST_NOTFOUND;
				end else if (have_prv && (dc > dp)) begin
					d_res.start  = prv.start;
					d_res.length = prv.length;
					d_res.value  = prv.value;
				end else begin
					d_res.start  = cand.start;
					d_res.length = cand.length;
					d_res.value  = cand.value;
				end
			end
			default: begin
				d_res.status = ST_INVALID;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			nn_q      <= '0;
			i_q       <= '0;
			m_q       <= '0;
			k_q       <= '0;
			lo_q      <= '0;
			found_q   <= 1'b0;
			two_q     <= 1'b0;
			op_q      <= '0;
			rng_ok_q  <= 1'b0;
			s_q       <= '0;
			len_q     <= '0;
			val_q     <= '0;
			e_q       <= '0;
			cur_q     <= '0;
			p1_q      <= '0;
			p2_q      <= '0;
			wa_addr_q <= '0;
			wb_addr_q <= '0;
			wa_data_q <= '0;
			wb_data_q <= '0;
			res_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= req_type;
						s_q      <= req_start;
						len_q    <= req_length;
						val_q    <= new_value;
						e_q      <= e_in;
						rng_ok_q <= (req_length != '0) && (e_in <= ADDR_LIMIT);
						i_q      <= '0;
						k_q      <= '0;
						found_q  <= 1'b0;
						two_q    <= 1'b0;
						if (req_type == REQ_FIND || req_type == REQ_NEAREST ||
							((req_type == REQ_INSERT || req_type == REQ_REMOVE) &&
							(req_length != '0) && (e_in <= ADDR_LIMIT))) begin
							state_q <= S_SCAN_RD;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= (i_q == n_q) ? S_DECIDE : S_SCAN_EV;
				end
				S_SCAN_EV: begin
					// stop at the first entry past the request point (at it, for an insert; ending past it, for a remove)
					if ((op_q == REQ_INSERT && rd_q.start >= s_q) ||
						(op_q == REQ_REMOVE && x_end > {1'b0, s_q}) ||
						((op_q == REQ_FIND || op_q == REQ_NEAREST) && rd_q.start > s_q)) begin
						cur_q   <= rd_q;
						found_q <= 1'b1;
						state_q <= S_DECIDE;
					end else begin
						p2_q    <= p1_q;
						p1_q    <= rd_q;
						i_q     <= i_inc;
						state_q <= S_SCAN_RD;
					end
				end
				S_DECIDE: begin
					res_q     <= d_res;
					nn_q      <= d_nn;
					n_q       <= d_n;
					two_q     <= d_two;
					wa_addr_q <= d_wa_addr;
					wa_data_q <= d_wa_data;
					wb_addr_q <= d_wb_addr;
					wb_data_q <= d_wb_data;
					lo_q      <= d_lo;
					i_q       <= d_i;
					m_q       <= d_m;
					state_q   <= d_state;
				end
				S_SHUP_RD: begin
					state_q <= S_SHUP_WR;
				end
				S_SHUP_WR: begin
					i_q     <= i_dec;
					state_q <= (i_dec > lo_q) ? S_SHUP_RD : S_WR_A;
				end
				S_SHDN_RD: begin
					state_q <= S_SHDN_WR;
				end
				S_SHDN_WR: begin
					i_q     <= i_inc;
					state_q <= (i_inc2 + (CW + 1)'(1) <= n_ext) ? S_SHDN_RD : S_WR_A;
				end
				S_WR_A: begin
					if (two_q) begin
						state_q <= S_WR_B;
					end else begin
						n_q     <= nn_q;
						state_q <= S_EMIT;
					end
				end
				S_WR_B: begin
					n_q     <= nn_q;
					state_q <= S_EMIT;
				end
				S_RM_RD: begin
					if (i_q == n_q) begin
						n_q          <= m_q;
						res_q.rcount <= 6'(k_q);
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_RM_EV;
					end
				end
				S_RM_EV: begin
					// hold on a deleted entry until its beat fits in the output
					if (rm_del) begin
						if (out_free) begin
							k_q     <= k_q + CW'(1);
							i_q     <= i_inc;
							state_q <= S_RM_RD;
						end
					end else begin
						m_q     <= m_q + CW'(1);
						i_q     <= i_inc;
						state_q <= S_RM_RD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign range_start      = out_q.start;
	assign range_length     = out_q.length;
	assign entry_value      = out_q.value;
	assign merged_value     = out_q.m1;
	assign merged_value_two = out_q.m2;
	assign merged_count     = out_q.mcount;
	assign deleted_count    = out_q.rcount;
	assign last             = out_q.last;

	`CRT_ASSERT_NOW(a_count_bound, 1'b1, n_q <= DEPTH_C, "entry count beyond depth")
	`CRT_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != S_IDLE, "no busy after accept")
	`CRT_ASSERT_NOW(a_compact_order, state_q == S_RM_EV, m_q <= i_q, "compaction overtook read")
	`CRT_ASSERT_NOW(a_scan_bound, state_q == S_SCAN_EV, i_q < n_q, "scan past entry count")
	`CRT_ASSERT_NEXT(a_emit_done, state_q == S_EMIT && out_free, state_q == S_IDLE, "emit stuck")

endmodule

>>> dv/coalescing_range_table_tb.sv
// -----------------------------------------------------------------------------
// coalescing_range_table_tb
// Drives insert, remove, find, nearest and clear requests into the interval
// table, predicts every result beat from a local copy of the table, and checks
// each output beat field by field, in order, against the predicted stream.
// -----------------------------------------------------------------------------
module coalescing_range_table_tb;
	import crt_pkg::*;

	localparam int          TBL_DEPTH = 32;
	localparam longint      END_LIMIT = 64'hFFFF_FFFF;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] start;
		logic [31:0] length;
		logic [31:0] value;
		bit          drain;   // pause marker: offer nothing until all beats are back
	} req_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic [31:0] req_start = '0;
	logic [31:0] req_length = '0;
	logic [31:0] new_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] range_start;
	logic [31:0] range_length;
	logic [31:0] entry_value;
	logic [31:0] merged_value;
	logic [31:0] merged_value_two;
	logic [1:0]  merged_count;
	logic [5:0]  deleted_count;
	logic        last;

	coalescing_range_table DUT (.*);

	always #5 clk = ~clk;

	// Shadow copy of the interval table.
	logic [31:0] tbl_start [TBL_DEPTH];
	logic [31:0] tbl_len   [TBL_DEPTH];
	logic [31:0] tbl_val   [TBL_DEPTH];
	int          tbl_n = 0;

	req_item_t pending_q[$];
	result_t   beat_q[$];     // predicted result beats, oldest first
	int        n_accepted = 0;
	int        n_errors = 0;
	bit        hold_done = 1'b0;
	int        hold_cnt = 0;

	function automatic void push_beat(logic [1:0] st, logic [31:0] s, logic [31:0] l,
			logic [31:0] v, logic [31:0] m1, logic [31:0] m2, int mc, int rc, int lst);
		result_t r;
		r.status = st; r.start = s; r.length = l; r.value = v;
		r.m1 = m1; r.m2 = m2; r.mcount = 2'(mc); r.rcount = 6'(rc); r.last = 1'(lst);
		beat_q.push_back(r);
	endfunction

	function automatic longint tbl_end(int i);
		return longint'(tbl_start[i]) + longint'(tbl_len[i]);
	endfunction

	function automatic void predict_insert(logic [31:0] s, logic [31:0] len, logic [31:0] v);
		longint e;
		int     idx;
		bit     lft, rgt;
		logic [31:0] mv;
		e = longint'(s) + longint'(len);
		idx = 0;
		if (len == 0 || e > END_LIMIT) begin
			push_beat(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		while (idx < tbl_n && tbl_start[idx] < s) idx++;
		// reject any overlap with a stored neighbor
		if ((idx > 0 && tbl_end(idx - 1) > s) || (idx < tbl_n && e > tbl_start[idx])) begin
			push_beat(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		lft = idx > 0 && tbl_end(idx - 1) == s;
		rgt = idx < tbl_n && e == tbl_start[idx];
		if (lft && rgt) begin
			mv = tbl_val[idx];
			tbl_len[idx - 1] = tbl_len[idx - 1] + len + tbl_len[idx];
			for (int i = idx; i + 1 < tbl_n; i++) begin
				tbl_start[i] = tbl_start[i + 1];
				tbl_len[i] = tbl_len[i + 1];
				tbl_val[i] = tbl_val[i + 1];
			end
			tbl_n--;
			push_beat(ST_OK, tbl_start[idx - 1], tbl_len[idx - 1], tbl_val[idx - 1],
				v, mv, 2, 0, 1);
		end else if (lft) begin
			tbl_len[idx - 1] = tbl_len[idx - 1] + len;
			push_beat(ST_OK, tbl_start[idx - 1], tbl_len[idx - 1], tbl_val[idx - 1],
				v, 0, 1, 0, 1);
		end else if (rgt) begin
			mv = tbl_val[idx];
			tbl_start[idx] = s;
			tbl_len[idx] = tbl_len[idx] + len;
			tbl_val[idx] = v;
			push_beat(ST_OK, s, tbl_len[idx], v, mv, 0, 1, 0, 1);
		end else if (tbl_n >= TBL_DEPTH) begin
			push_beat(ST_FULL, 0, 0, 0, 0, 0, 0, 0, 1);
		end else begin
			for (int i = tbl_n; i > idx; i--) begin
				tbl_start[i] = tbl_start[i - 1];
				tbl_len[i] = tbl_len[i - 1];
				tbl_val[i] = tbl_val[i - 1];
			end
			tbl_start[idx] = s; tbl_len[idx] = len; tbl_val[idx] = v;
			tbl_n++;
			push_beat(ST_OK, s, len, v, 0, 0, 0, 0, 1);
		end
	endfunction

	function automatic void predict_remove(logic [31:0] s, logic [31:0] len);
		logic [31:0] ks [TBL_DEPTH];
		logic [31:0] kl [TBL_DEPTH];
		logic [31:0] kv [TBL_DEPTH];
		longint e, en;
		int m, k;
		e = longint'(s) + longint'(len);
		m = 0;
		k = 0;
		if (len == 0 || e > END_LIMIT) begin
			push_beat(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		// a split needs a free entry
		if (tbl_n >= TBL_DEPTH)
			for (int i = 0; i < tbl_n; i++)
				if (tbl_start[i] < s && tbl_end(i) > e) begin
					push_beat(ST_FULL, 0, 0, 0, 0, 0, 0, 0, 1);
					return;
				end
		for (int i = 0; i < tbl_n; i++) begin
			en = tbl_end(i);
			if (en <= s || tbl_start[i] >= e) begin
				if (m < TBL_DEPTH) begin
					ks[m] = tbl_start[i]; kl[m] = tbl_len[i]; kv[m] = tbl_val[i]; m++;
				end
			end else if (tbl_start[i] >= s && en <= e) begin
				push_beat(ST_OK, tbl_start[i], tbl_len[i], tbl_val[i], 0, 0, 0, 0, 0);
				k++;
			end else begin
				if (tbl_start[i] < s && m < TBL_DEPTH) begin
					ks[m] = tbl_start[i]; kl[m] = s - tbl_start[i]; kv[m] = tbl_val[i]; m++;
				end
				if (en > e && m < TBL_DEPTH) begin
					ks[m] = e[31:0]; kl[m] = 32'(en - e); kv[m] = tbl_val[i]; m++;
				end
			end
		end
		for (int i = 0; i < m; i++) begin
			tbl_start[i] = ks[i]; tbl_len[i] = kl[i]; tbl_val[i] = kv[i];
		end
		tbl_n = m;
		push_beat(ST_OK, 0, 0, 0, 0, 0, 0, k, 1);
	endfunction

	function automatic void predict_find(logic [31:0] loc, bit nearest);
		int idx;
		longint dc, dp;
		idx = 0;
		for (int i = 0; i < tbl_n; i++)
			if (tbl_start[i] <= loc && tbl_end(i) > loc) begin
				push_beat(ST_OK, tbl_start[i], tbl_len[i], tbl_val[i], 0, 0, 0, 0, 1);
				return;
			end
		if (!nearest || tbl_n == 0) begin
			push_beat(ST_NOTFOUND, 0, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		while (idx < tbl_n && tbl_start[idx] <= loc) idx++;
		if (idx == tbl_n) idx = tbl_n - 1;
		if (idx > 0) begin
			dc = tbl_start[idx] > loc ? longint'(tbl_start[idx]) - longint'(loc)
			                          : longint'(loc) - tbl_end(idx) + 1;
			dp = longint'(loc) - tbl_end(idx - 1) + 1;
			// equal distance keeps the later interval
			if (dc > dp) idx--;
		end
		push_beat(ST_OK, tbl_start[idx], tbl_len[idx], tbl_val[idx], 0, 0, 0, 0, 1);
	endfunction

	function automatic void predict_request(logic [2:0] kind, logic [31:0] s,
			logic [31:0] len, logic [31:0] v);
		case (kind)
			REQ_INSERT:  predict_insert(s, len, v);
			REQ_REMOVE:  predict_remove(s, len);
			REQ_FIND:    predict_find(s, 1'b0);
			REQ_NEAREST: predict_find(s, 1'b1);
			REQ_CLEAR: begin
				tbl_n = 0;
				push_beat(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1);
			end
			default:     push_beat(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 1);
		endcase
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("beat error: %s got %0h want %0h (t=%0t)", field, got, want, $time);
		n_errors++;
	endtask

	// Idle rates per stage: sender-heavy receiver stalls, then swapped, then none.
	function automatic int send_idle_pct();
		if (n_accepted < 70) return 28;
		if (n_accepted < 140) return 87;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (n_accepted < 70) return 87;
		if (n_accepted < 140) return 28;
		return 0;
	endfunction

	// Driver: predict on each accepted beat, hold a stalled beat, else offer the next.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_request(req_type, req_start, req_length, new_value);
				n_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_q.size() > 0 && pending_q[0].drain) begin
					in_valid <= 1'b0;
					if (beat_q.size() == 0 && !(in_valid && !in_stall))
						void'(pending_q.pop_front());
				end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
					req_item_t it;
					it = pending_q.pop_front();
					in_valid <= 1'b1;
					req_type <= it.kind;
					req_start <= it.start;
					req_length <= it.length;
					new_value <= it.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver backpressure, with one long hold-off to back up the request side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_accepted >= 150) begin
				hold_done <= 1'b1;
				hold_cnt <= 400;
				out_stall <= 1'b1;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(99) < recv_idle_pct();
			end
		end
	end

	// Monitor: check each delivered beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (beat_q.size() == 0) begin
				report("unexpected beat", {30'd0, status}, 0);
			end else begin
				result_t w;
				w = beat_q.pop_front();
				if (status !== w.status) report("status", 32'(status), 32'(w.status));
				if (range_start !== w.start) report("range_start", range_start, w.start);
				if (range_length !== w.length) report("range_length", range_length, w.length);
				if (entry_value !== w.value) report("entry_value", entry_value, w.value);
				if (merged_value !== w.m1) report("merged_value", merged_value, w.m1);
				if (merged_value_two !== w.m2)
					report("merged_value_two", merged_value_two, w.m2);
				if (merged_count !== w.mcount)
					report("merged_count", 32'(merged_count), 32'(w.mcount));
				if (deleted_count !== w.rcount)
					report("deleted_count", 32'(deleted_count), 32'(w.rcount));
				if (last !== w.last) report("last", 32'(last), 32'(w.last));
			end
		end
	end

	task automatic add(logic [2:0] kind, logic [31:0] s, logic [31:0] len, logic [31:0] v);
		req_item_t it;
		it.kind = kind; it.start = s; it.length = len; it.value = v; it.drain = 1'b0;
		pending_q.push_back(it);
	endtask

	task automatic add_drain();
		req_item_t it;
		it.kind = REQ_CLEAR; it.start = 0; it.length = 0; it.value = 0; it.drain = 1'b1;
		pending_q.push_back(it);
	endtask

	initial begin
		int pick;
		int b;
		// directed: empty table, invalid ranges, extremes, every merge shape, ties
		add(REQ_FIND, 0, 0, 0);
		add(REQ_NEAREST, 32'hFFFF_FFFF, 0, 0);
		add(REQ_INSERT, 0, 0, 32'h1);
		add(REQ_INSERT, 32'hFFFF_FFFF, 1, 32'h2);
		add(REQ_INSERT, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add(REQ_FIND, 32'hFFFF_FFFE, 0, 0);
		add(REQ_INSERT, 7, 3, 32'h3);
		add(REQ_REMOVE, 5, 10, 0);
		add(REQ_REMOVE, 0, 32'hFFFF_FFFF, 0);
		add(REQ_INSERT, 100, 10, 32'hA);
		add(REQ_INSERT, 120, 10, 32'hB);
		add(REQ_INSERT, 110, 10, 32'hC);
		add(REQ_INSERT, 130, 5, 32'hD);
		add(REQ_INSERT, 95, 5, 32'hE);
		add(REQ_INSERT, 140, 10, 32'hF);
		add(REQ_NEAREST, 137, 0, 0);
		add(REQ_NEAREST, 90, 0, 0);
		add(REQ_NEAREST, 200, 0, 0);
		add(REQ_FIND, 120, 0, 0);
		add(REQ_FIND, 136, 0, 0);
		add(REQ_REMOVE, 98, 0, 0);
		add(REQ_REMOVE, 90, 100, 0);
		add(3'd5, 1, 1, 1);
		add(3'd7, 0, 0, 0);
		add(REQ_CLEAR, 0, 0, 0);
		add_drain();

		// random: mostly well-formed traffic in a small window, some bursts, some noise
		for (int n = 0; n < 175; ) begin
			pick = $urandom_range(99);
			if (pick < 8 && n > 20) begin
				// fill to capacity, then hit the full cases
				add(REQ_CLEAR, 0, 0, 0);
				b = $urandom_range(0, 1000);
				for (int i = 0; i < TBL_DEPTH + 1; i++)
					add(REQ_INSERT, b + i * 16, $urandom_range(2, 8), $urandom());
				add(REQ_REMOVE, b + 16 * 5 + 1, 1, 0);
				add(REQ_REMOVE, b, $urandom_range(16, 700), 0);
				n += 36;
			end else if (pick < 20) begin
				// three-way merge with random content
				b = $urandom_range(0, 400);
				add(REQ_INSERT, b, 4, $urandom());
				add(REQ_INSERT, b + 8, 4, $urandom());
				add(REQ_INSERT, b + 4, 4, $urandom());
				n += 3;
			end else if (pick < 33) begin
				add(3'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom());
				n++;
			end else begin
				pick = $urandom_range(99);
				add(pick < 45 ? REQ_INSERT : pick < 65 ? REQ_REMOVE :
				    pick < 80 ? REQ_FIND : pick < 97 ? REQ_NEAREST : REQ_CLEAR,
				    $urandom_range(0, 511), $urandom_range(1, 24), $urandom());
				n++;
			end
			if (n > 60 && n < 66) add_drain();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0 && !in_valid);
		wait (beat_q.size() == 0);
		repeat (300) @(posedge clk);
		if (n_errors == 0 && beat_q.size() == 0)
			$display("coalescing_range_table: match");
		else
			$display("coalescing_range_table: mismatch");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("coalescing_range_table: mismatch");
		$finish;
	end

endmodule
